@@ hw/rtl/text_console_writer_assert.svh @@
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared concurrent assertion forms for the console rtl
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// condition and consequence in the same cycle
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// geometry, store and character code constants of the text console writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int MAX_ROWS    = 50;
  localparam int MAX_COLUMNS = 80;
  localparam int STORE_CELLS = MAX_ROWS * MAX_COLUMNS;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int ADDR_W = 12;
  localparam int PROD_W = ROW_W + COL_W;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam int TAB_STOP_BITS = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_ATTR    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  localparam logic [ROW_W-1:0]  ROWS_RESET = 6'd25;
  localparam logic [COL_W-1:0]  COLS_RESET = 7'd80;
  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'd7;

endpackage

@@ hw/rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console: screen store of attribute/character cells and a cursor
// ----------------------------------------------------------------------------
// A request either puts one byte on the screen (carriage return, line feed,
// backspace, tab or a printable byte) or reads one stored cell; each request
// returns one result with the cursor position after the step. The screen sits
// in one 4000 x 16 synchronous memory with one read and one write port: after
// reset a clearing pass writes every cell blank before the first request is
// taken. A tab writes spaces up to the next tab stop, up to 7 of them. A step
// that scrolls moves the screen one cell per cycle. A result held by out_stall
// keeps the next step waiting in its last cycle. Configuration writes are taken
// at any time but belong in idle periods.
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

module text_console_writer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]     in_character,
  input  logic [tcw_pkg::ADDR_W-1:0]     in_cell_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcw_pkg::ADDR_W-1:0]     out_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]     out_cell_data,
  output logic                           out_scrolled,
  input  logic                           cfg_write_en,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import tcw_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_PUT    = 8'b0000_1000,
    S_RDWAIT = 8'b0001_0000,
    S_SCROLL = 8'b0010_0000,
    S_BLANK  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic                cmd_r, cmd_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   keep_r, keep_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic                scrolled_r, scrolled_nxt;
  logic [CELL_W-1:0]   data_r, data_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_pos_r, out_pos_nxt;
  logic [CELL_W-1:0]   out_data_r, out_data_nxt;
  logic                out_scr_r, out_scr_nxt;

  logic [ROW_W-1:0]    rows_cfg_r;
  logic [COL_W-1:0]    cols_cfg_r;
  logic [CHAR_W-1:0]   attr_r;

  logic [CELL_W-1:0]   mem [STORE_CELLS];
  logic [CELL_W-1:0]   mem_rdata_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  logic [ROW_W-1:0]    geo_rows;
  logic [COL_W-1:0]    geo_cols;
  logic [ROW_W:0]      row_inc;
  logic [COL_W:0]      col_inc;
  logic [PROD_W-1:0]   cur_prod;
  logic [PROD_W-1:0]   keep_prod;
  logic [ADDR_W-1:0]   cur_loc;
  logic [ADDR_W-1:0]   blank_end;
  logic [CHAR_W-1:0]   put_char;
  logic                in_accept;
  logic                out_load;
  logic                scroll_rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_RESET;
      cols_cfg_r <= COLS_RESET;
      attr_r     <= ATTR_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_ROWS:    rows_cfg_r <= cfg_wdata[ROW_W-1:0];
        CFG_COLUMNS: cols_cfg_r <= cfg_wdata[COL_W-1:0];
        CFG_ATTR:    attr_r     <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // geometry saturated into the store limits
  always_comb begin
    if (rows_cfg_r == '0) begin
      geo_rows = ROW_W'(1);
    end else if (rows_cfg_r > ROW_W'(MAX_ROWS)) begin
      geo_rows = ROW_W'(MAX_ROWS);
    end else begin
      geo_rows = rows_cfg_r;
    end
    if (cols_cfg_r == '0) begin
      geo_cols = COL_W'(1);
    end else if (cols_cfg_r > COL_W'(MAX_COLUMNS)) begin
      geo_cols = COL_W'(MAX_COLUMNS);
    end else begin
      geo_cols = cols_cfg_r;
    end
  end

  assign row_inc   = {1'b0, row_r} + 1'b1;
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign cur_prod  = PROD_W'(row_r) * PROD_W'(geo_cols);
  assign cur_loc   = ADDR_W'(cur_prod + PROD_W'(col_r));
  assign keep_prod = PROD_W'(geo_rows - 1'b1) * PROD_W'(geo_cols);
  assign blank_end = keep_r + ADDR_W'(geo_cols) - 1'b1;
  assign put_char  = (char_r == CH_TAB) ? CH_SPACE : char_r;
  assign scroll_rd = (state_r == S_SCROLL) && (cnt_r < keep_r);

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cmd_nxt       = cmd_r;
    char_nxt      = char_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    keep_nxt      = keep_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = cnt_r;
    scrolled_nxt  = scrolled_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_data_nxt  = out_data_r;
    out_scr_nxt   = out_scr_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = BLANK_CELL;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // delayed half of a scroll copy: the read data lands in the next cycle
    if (pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = mem_rdata_r;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_r == ADDR_W'(STORE_CELLS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt      = in_command;
          char_nxt     = in_character;
          addr_nxt     = in_cell_address;
          scrolled_nxt = 1'b0;
          data_nxt     = '0;
          // cursor left off screen by a geometry change
          if (row_r >= geo_rows) row_nxt = geo_rows - 1'b1;
          if (col_r >= geo_cols) col_nxt = geo_cols - 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cmd_r == CMD_READ) begin
          if (32'(addr_r) < STORE_CELLS) begin
            mem_re    = 1'b1;
            mem_raddr = addr_r;
            state_nxt = S_RDWAIT;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          case (char_r)
            CH_CR: begin
              col_nxt   = '0;
              state_nxt = S_DONE;
            end
            CH_LF: begin
              if (row_inc >= {1'b0, geo_rows}) begin
                row_nxt      = geo_rows - 1'b1;
                cnt_nxt      = '0;
                keep_nxt     = ADDR_W'(keep_prod);
                scrolled_nxt = 1'b1;
                state_nxt    = S_SCROLL;
              end else begin
                row_nxt   = row_inc[ROW_W-1:0];
                state_nxt = S_DONE;
              end
            end
            CH_BS: begin
              if (col_r != '0) begin
                col_nxt   = col_r - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = cur_loc - 1'b1;
                mem_wdata = {attr_r, CH_SPACE};
              end
              state_nxt = S_DONE;
            end
            CH_TAB: begin
              if (col_r[TAB_STOP_BITS-1:0] == '0) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_PUT;
              end
            end
            default: state_nxt = S_PUT;
          endcase
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_loc;
        mem_wdata = {attr_r, put_char};
        if (col_inc >= {1'b0, geo_cols}) begin
          col_nxt = '0;
          if (row_inc >= {1'b0, geo_rows}) begin
            row_nxt      = geo_rows - 1'b1;
            cnt_nxt      = '0;
            keep_nxt     = ADDR_W'(keep_prod);
            scrolled_nxt = 1'b1;
            state_nxt    = S_SCROLL;
          end else begin
            row_nxt   = row_inc[ROW_W-1:0];
            state_nxt = S_DONE;
          end
        end else begin
          col_nxt = col_inc[COL_W-1:0];
          if (char_r != CH_TAB || col_inc[TAB_STOP_BITS-1:0] == '0) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_RDWAIT: begin
        data_nxt  = mem_rdata_r;
        state_nxt = S_DONE;
      end

      S_SCROLL: begin
        if (scroll_rd) begin
          mem_re        = 1'b1;
          mem_raddr     = cnt_r + ADDR_W'(geo_cols);
          pend_nxt      = 1'b1;
          pend_addr_nxt = cnt_r;
          cnt_nxt       = cnt_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_BLANK;
        end
      end

      S_BLANK: begin
        mem_we = 1'b1;
        if (cnt_r == blank_end) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = cur_loc;
          out_data_nxt  = data_r;
          out_scr_nxt   = scrolled_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    char_r      <= char_nxt;
    addr_r      <= addr_nxt;
    keep_r      <= keep_nxt;
    pend_addr_r <= pend_addr_nxt;
    scrolled_r  <= scrolled_nxt;
    data_r      <= data_nxt;
    out_pos_r   <= out_pos_nxt;
    out_data_r  <= out_data_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  // screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_data       = out_data_r;
  assign out_scrolled        = out_scr_r;

  `TCW_ASSERT_SAME(a_write_in_store, clk, rst_n, mem_we, 32'(mem_waddr) < STORE_CELLS,
                   "store write beyond last cell")
  `TCW_ASSERT_SAME(a_cursor_on_screen, clk, rst_n, out_load,
                   row_r < geo_rows && col_r < geo_cols, "cursor off screen at result")
  `TCW_ASSERT_SAME(a_scroll_only_on_put, clk, rst_n, out_load && scrolled_r,
                   cmd_r == CMD_PUT, "read request reported a scroll")
  `TCW_ASSERT_NEXT(a_copy_lag, clk, rst_n, scroll_rd,
                   mem_we && mem_waddr == $past(cnt_r), "scroll copy write lost")

endmodule

@@ sim/text_console_writer_checker.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_checker
// mirrors the console screen, cursor and geometry from the observed requests
// and register writes, predicts each result and compares it with the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]     in_character,
  input  logic [tcw_pkg::ADDR_W-1:0]     in_cell_address,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [tcw_pkg::ADDR_W-1:0]     out_cursor_position,
  input  logic [tcw_pkg::CELL_W-1:0]     out_cell_data,
  input  logic                           out_scrolled,
  input  logic                           cfg_write_en,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             waiting
);

  import tcw_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } console_result_t;

  console_result_t   pending_results[$];
  logic [CELL_W-1:0] screen [STORE_CELLS];
  int                cur_row, cur_col;
  int                rows_reg, cols_reg;
  logic [7:0]        attr_reg;
  int                view_rows, view_cols;
  bit                rolled;

  task automatic write_cell(input logic [CHAR_W-1:0] ch);
    int loc;
    loc = cur_row * view_cols + cur_col;
    if (loc < STORE_CELLS) screen[loc] = {attr_reg, ch};
  endtask

  // move down one row; at the bottom the screen rolls up and the last row blanks
  task automatic line_down();
    int keep;
    cur_row++;
    if (cur_row >= view_rows) begin
      keep = (view_rows - 1) * view_cols;
      for (int i = 0; i < keep; i++) screen[i] = screen[i + view_cols];
      for (int i = keep; i < keep + view_cols; i++) screen[i] = BLANK_CELL;
      rolled  = 1'b1;
      cur_row = view_rows - 1;
    end
  endtask

  task automatic print_char(input logic [CHAR_W-1:0] ch);
    write_cell(ch);
    cur_col++;
    if (cur_col >= view_cols) begin
      cur_col = 0;
      line_down();
    end
  endtask

  task automatic console_step(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                              input logic [ADDR_W-1:0] addr,
                              output console_result_t res);
    logic [CELL_W-1:0] data;
    view_rows = (rows_reg < 1) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    view_cols = (cols_reg < 1) ? 1 : (cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : cols_reg;
    // a cursor left beyond a shrunk screen sticks to the last row or column
    if (cur_row >= view_rows) cur_row = view_rows - 1;
    if (cur_col >= view_cols) cur_col = view_cols - 1;
    rolled = 1'b0;
    data   = '0;
    if (cmd == CMD_READ) begin
      if (addr < STORE_CELLS) data = screen[addr];
    end else begin
      case (ch)
        CH_TAB: begin
          while ((cur_col % (1 << TAB_STOP_BITS)) != 0) print_char(CH_SPACE);
        end
        CH_CR: cur_col = 0;
        CH_LF: line_down();
        CH_BS: begin
          if (cur_col > 0) begin
            cur_col--;
            write_cell(CH_SPACE);
          end
        end
        default: print_char(ch);
      endcase
    end
    res.cursor_position = ADDR_W'(cur_row * view_cols + cur_col);
    res.cell_data       = data;
    res.scrolled        = rolled;
  endtask

  always @(posedge clk) begin
    console_result_t res;
    if (!rst_n) begin
      for (int i = 0; i < STORE_CELLS; i++) screen[i] = BLANK_CELL;
      cur_row    = 0;
      cur_col    = 0;
      rows_reg   = int'(ROWS_RESET);
      cols_reg   = int'(COLS_RESET);
      attr_reg   = ATTR_RESET;
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ROWS:    rows_reg = int'(cfg_wdata[ROW_W-1:0]);
          CFG_COLUMNS: cols_reg = int'(cfg_wdata[COL_W-1:0]);
          CFG_ATTR:    attr_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        console_step(cmd_t'(in_command), in_character, in_cell_address, res);
        pending_results.push_back(res);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: cursor_position %0d cell_data %h scrolled %0b",
                   $time, out_cursor_position, out_cell_data, out_scrolled);
        end else begin
          res = pending_results.pop_front();
          if (out_cursor_position !== res.cursor_position) begin
            mismatches++;
            $display("%0t cursor_position expected %0d got %0d",
                     $time, res.cursor_position, out_cursor_position);
          end
          if (out_cell_data !== res.cell_data) begin
            mismatches++;
            $display("%0t cell_data expected %h got %h",
                     $time, res.cell_data, out_cell_data);
          end
          if (out_scrolled !== res.scrolled) begin
            mismatches++;
            $display("%0t scrolled expected %0b got %0b",
                     $time, res.scrolled, out_scrolled);
          end
        end
      end
    end
    waiting <= pending_results.size();
  end

endmodule

@@ sim/text_console_writer_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_tb
// drives put and read requests through several screen geometries and
// attributes with random idling on both channels; the checker predicts and
// compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int TARGET_REQUESTS = 1950;
  localparam int QUIET_LIMIT     = 40000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = 1'b0;
  logic [CHAR_W-1:0]     in_character = '0;
  logic [ADDR_W-1:0]     in_cell_address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ADDR_W-1:0]     out_cursor_position;
  logic [CELL_W-1:0]     out_cell_data;
  logic                  out_scrolled;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatches, waiting;
  int sent = 0;
  int quiet = 0;
  int geo_rows = int'(ROWS_RESET);
  int geo_cols = int'(COLS_RESET);
  bit calm = 1'b0;

  text_console_writer uut (.*);

  text_console_writer_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 27);

  // no request accepted and no result taken for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("text_console_writer_tb: errors");
      $finish;
    end
  end

  task automatic send_request(input cmd_t cmd, input logic [CHAR_W-1:0] ch,
                              input logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_character    <= ch;
    in_cell_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stop sending and wait for every outstanding result, then some extra cycles
  task automatic settle_console(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_console(input logic [7:0] rows, input logic [7:0] cols,
                                 input logic [7:0] attr);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_ROWS;
    cfg_wdata    <= rows;
    @(posedge clk);
    cfg_index    <= CFG_COLUMNS;
    cfg_wdata    <= cols;
    @(posedge clk);
    cfg_index    <= CFG_ATTR;
    cfg_wdata    <= attr;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    geo_rows = (int'(rows[ROW_W-1:0]) < 1) ? 1 :
               (int'(rows[ROW_W-1:0]) > MAX_ROWS) ? MAX_ROWS : int'(rows[ROW_W-1:0]);
    geo_cols = (int'(cols[COL_W-1:0]) < 1) ? 1 :
               (int'(cols[COL_W-1:0]) > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols[COL_W-1:0]);
  endtask

  task automatic random_request();
    int pick;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom_range(0, 255));
    addr = ADDR_W'($urandom_range(0, 4095));
    if (pick < 20) begin
      // mostly cells that are on screen, the rest anywhere in the address range
      if (pick < 13) addr = ADDR_W'($urandom_range(0, geo_rows * geo_cols - 1));
      send_request(CMD_READ, ch, addr);
    end else begin
      if (pick < 32) ch = CH_LF;
      else if (pick < 40) ch = CH_CR;
      else if (pick < 48) ch = CH_BS;
      else if (pick < 58) ch = CH_TAB;
      send_request(CMD_PUT, ch, addr);
    end
  endtask

  initial begin
    int phase;
    int count;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at reset geometry
    send_request(CMD_READ, 8'h00, 12'd0);
    send_request(CMD_READ, 8'hFF, 12'hFFF);
    send_request(CMD_READ, 8'h00, 12'd4000);
    send_request(CMD_READ, 8'h00, 12'd3999);
    send_request(CMD_PUT, CH_BS, 12'd0);
    send_request(CMD_PUT, CH_TAB, 12'd0);
    send_request(CMD_PUT, 8'h41, 12'd0);
    send_request(CMD_PUT, 8'hFF, 12'hFFF);
    send_request(CMD_PUT, 8'h00, 12'd0);
    send_request(CMD_PUT, 8'h80, 12'd0);
    send_request(CMD_PUT, CH_TAB, 12'd0);
    send_request(CMD_PUT, CH_BS, 12'd0);
    send_request(CMD_PUT, CH_CR, 12'd0);
    send_request(CMD_PUT, CH_LF, 12'd0);
    send_request(CMD_PUT, 8'h7F, 12'd0);
    send_request(CMD_READ, 8'h00, 12'd0);
    send_request(CMD_READ, 8'h00, 12'd1);
    send_request(CMD_READ, 8'h00, 12'd7);
    send_request(CMD_READ, 8'h00, 12'd80);
    send_request(CMD_READ, 8'h00, 12'd2000);

    phase = 0;
    while (sent < TARGET_REQUESTS) begin
      settle_console(8);
      count = $urandom_range(60, 100);
      case (phase)
        0: program_console(8'h01, 8'h01, 8'h00);
        1: program_console(8'hC0, 8'h80, 8'hFF);
        2: begin
          program_console(8'hFF, 8'hFF, 8'($urandom_range(0, 255)));
          count = 40;
        end
        3: program_console(8'd50, 8'd80, 8'($urandom_range(0, 255)));
        4: program_console(8'(ROWS_RESET), 8'(COLS_RESET), ATTR_RESET);
        default: begin
          if (phase % 6 == 5)
            program_console(8'($urandom_range(1, 50)), 8'($urandom_range(1, 80)),
                            8'($urandom_range(0, 255)));
          else if (phase % 7 == 3)
            program_console(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
          else
            program_console(8'($urandom_range(1, 8)), 8'($urandom_range(1, 24)),
                            8'($urandom_range(0, 255)));
        end
      endcase
      calm = (phase == 5);
      for (int n = 0; n < count; n++) begin
        if (phase == 6 && n == 30) settle_console(0);
        random_request();
      end
      // walk to the bottom of the full screen so it rolls at least once
      if (phase == 2) begin
        for (int n = 0; n < MAX_ROWS; n++) send_request(CMD_PUT, CH_LF, 12'd0);
      end
      phase++;
    end
    calm = 1'b0;

    settle_console(20);
    if (mismatches == 0) begin
      $display("text_console_writer_tb: clean");
    end else begin
      $display("text_console_writer_tb: errors");
    end
    $finish;
  end

endmodule
